// ===== rtl/vei_pkg.sv =====
// ----------------------------------------------------------------------------
// vei_pkg
// Shared widths, codes and pipeline types of the voxel edge indexer.
// ----------------------------------------------------------------------------
package vei_pkg;

  localparam int unsigned MAX_RANGE   = 1024;
  localparam int unsigned RW          = 11;  // range and endpoint coordinate width
  localparam int unsigned CW          = 10;  // cell coordinate width
  localparam int unsigned EW          = 4;   // local edge code width
  localparam int unsigned IW          = 32;  // global index width
  localparam int unsigned PW          = 21;  // plane size width, (MAX_RANGE+1)^2
  localparam int unsigned PLANE_STEPS = IW;  // quotient bits of rem / plane
  localparam int unsigned ROW_STEPS   = RW;  // quotient bits of rem % plane / row
  localparam int unsigned DIV_STAGES  = PLANE_STEPS + ROW_STEPS;

  localparam logic [1:0] REG_RANGE_X = 2'd0;
  localparam logic [1:0] REG_RANGE_Y = 2'd1;
  localparam logic [1:0] REG_RANGE_Z = 2'd2;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z,
    AX_NONE
  } axis_e;

  // grid geometry derived from the range registers
  typedef struct packed {
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [PW-1:0] px;   // rx*(ry+1)
    logic [PW-1:0] py;   // (rx+1)*ry
    logic [PW-1:0] pz;   // (rx+1)*(ry+1)
    logic [IW-1:0] xc;   // x edge count
    logic [IW-1:0] xyc;  // x plus y edge count
  } cfg_t;

  // one divider pipeline slot
  typedef struct packed {
    logic          valid;
    logic          cmd;
    axis_e         axis;
    logic [IW-1:0] num;    // forward index, or dividend shifting into quotient
    logic [PW-1:0] rmd;    // remainder of the plane divide, then row quotient bits
    logic [RW-1:0] part;   // partial remainder of the row divide
    logic [RW-1:0] row;
    logic [PW-1:0] plane;
  } pipe_t;

  function automatic logic [RW-1:0] eff_range(input logic [RW-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) begin
      r = RW'(1);
    end else if (v > RW'(MAX_RANGE)) begin
      r = RW'(MAX_RANGE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] sat_inc(input logic [RW-1:0] v);
    logic [RW-1:0] r;
    if (v >= RW'(MAX_RANGE)) begin
      r = RW'(MAX_RANGE);
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/voxel_edge_indexer.sv =====
// ----------------------------------------------------------------------------
// voxel_edge_indexer
// Marching-cubes edge to global edge number, and global number to endpoints.
// ----------------------------------------------------------------------------
//  channel   dir  signals                fields (low bit up)
//  s_axis    in   tvalid/tready/tdata    cell_x, cell_y, cell_z, local_edge,
//                 tuser                  global_index_in / cmd
//  m_axis    out  tvalid/tready/tdata    global_index_out, start_x..z, end_x..z
//  cfg       in   we/idx/data            0 range_x, 1 range_y, 2 range_z
//
//  One transaction per cycle while m_axis is not stalled; the pipeline is the
//  32 + 11 stage divider (one quotient bit per stage) plus input, product,
//  product delay, sum and output stages.
//  A range write updates a range register; the derived sizes and counts follow.
//  Reset sets all ranges to 1. A stall on m_axis freezes the whole pipeline.
// ----------------------------------------------------------------------------
module voxel_edge_indexer import vei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // cell_x[9:0], cell_y[19:10], cell_z[29:20], local_edge[33:30],
  // global_index_in[65:34], zero pad
  input  logic [71:0]   s_axis_tdata,
  // cmd
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // global_index_out[31:0], start_x[42:32], start_y[53:43], start_z[64:54],
  // end_x[75:65], end_y[86:76], end_z[97:87], zero pad
  output logic [103:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [RW-1:0] cfg_data_i
);

  logic          en;
  cfg_t          cfg;
  pipe_t         front, back;
  logic [IW-1:0] gidx;
  logic [RW-1:0] sx, sy, sz, ex, ey, ez;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  vei_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o      (cfg)
  );

  vei_front u_front (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_x_i     (s_axis_tdata[9:0]),
    .in_y_i     (s_axis_tdata[19:10]),
    .in_z_i     (s_axis_tdata[29:20]),
    .in_edge_i  (s_axis_tdata[33:30]),
    .in_gidx_i  (s_axis_tdata[65:34]),
    .out_o      (front)
  );

  vei_div u_div (
    .clk_i,
    .rst_ni,
    .en_i  (en),
    .in_i  (front),
    .out_o (back)
  );

  vei_back u_back (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .in_i    (back),
    .valid_o (m_axis_tvalid),
    .gidx_o  (gidx),
    .sx_o    (sx),
    .sy_o    (sy),
    .sz_o    (sz),
    .ex_o    (ex),
    .ey_o    (ey),
    .ez_o    (ez)
  );

  assign m_axis_tdata = {6'd0, ez, ey, ex, sz, sy, sx, gidx};

endmodule

// ===== rtl/vei_cfg.sv =====
// ----------------------------------------------------------------------------
// vei_cfg
// Range registers and the derived plane sizes and edge counts.
// ----------------------------------------------------------------------------
module vei_cfg import vei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [RW-1:0] cfg_data_i,
  output cfg_t          cfg_o
);

  logic [RW-1:0] rx_q, ry_q, rz_q;
  logic [PW-1:0] px_q, py_q, pz_q;
  logic [IW-1:0] xc_q, yc_q, xyc_q;
  logic [RW-1:0] rx1, ry1, rz1;

  assign rx1 = rx_q + 1'b1;
  assign ry1 = ry_q + 1'b1;
  assign rz1 = rz_q + 1'b1;

  // register steps: ranges, plane sizes, edge counts, then the x plus y sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q  <= RW'(1);
      ry_q  <= RW'(1);
      rz_q  <= RW'(1);
      px_q  <= PW'(2);
      py_q  <= PW'(2);
      pz_q  <= PW'(4);
      xc_q  <= IW'(4);
      yc_q  <= IW'(4);
      xyc_q <= IW'(8);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE_X: rx_q <= eff_range(cfg_data_i);
          REG_RANGE_Y: ry_q <= eff_range(cfg_data_i);
          REG_RANGE_Z: rz_q <= eff_range(cfg_data_i);
          default: ;
        endcase
      end
      px_q  <= PW'(rx_q * ry1);
      py_q  <= PW'(rx1 * ry_q);
      pz_q  <= PW'(rx1 * ry1);
      xc_q  <= IW'(px_q * rz1);
      yc_q  <= IW'(py_q * rz1);
      xyc_q <= xc_q + yc_q;
    end
  end

  assign cfg_o.rx  = rx_q;
  assign cfg_o.ry  = ry_q;
  assign cfg_o.px  = px_q;
  assign cfg_o.py  = py_q;
  assign cfg_o.pz  = pz_q;
  assign cfg_o.xc  = xc_q;
  assign cfg_o.xyc = xyc_q;

endmodule

// ===== rtl/vei_front.sv =====
// ----------------------------------------------------------------------------
// vei_front
// Input register, forward products, then forward sum or inverse axis pick.
// ----------------------------------------------------------------------------
module vei_front import vei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  input  logic [CW-1:0] in_x_i,
  input  logic [CW-1:0] in_y_i,
  input  logic [CW-1:0] in_z_i,
  input  logic [EW-1:0] in_edge_i,
  input  logic [IW-1:0] in_gidx_i,
  output pipe_t         out_o
);

  // marching-cubes edge codes, named by axis and the (+1, +1) offsets applied
  localparam logic [EW-1:0] EDGE_X00 = 4'd0;
  localparam logic [EW-1:0] EDGE_Y10 = 4'd1;
  localparam logic [EW-1:0] EDGE_X10 = 4'd2;
  localparam logic [EW-1:0] EDGE_Y00 = 4'd3;
  localparam logic [EW-1:0] EDGE_X01 = 4'd4;
  localparam logic [EW-1:0] EDGE_Y11 = 4'd5;
  localparam logic [EW-1:0] EDGE_X11 = 4'd6;
  localparam logic [EW-1:0] EDGE_Y01 = 4'd7;
  localparam logic [EW-1:0] EDGE_Z00 = 4'd8;
  localparam logic [EW-1:0] EDGE_Z10 = 4'd9;
  localparam logic [EW-1:0] EDGE_Z01 = 4'd10;
  localparam logic [EW-1:0] EDGE_Z11 = 4'd11;

  typedef struct packed {
    logic          valid;
    logic          cmd;
    axis_e         axis;
    logic [RW-1:0] xa;
    logic [2*RW-1:0] pa;
    logic [IW-1:0] pb;
    logic [IW-1:0] gidx;
  } mid_t;

  logic          s0_valid_q, s0_cmd_q;
  logic [CW-1:0] s0_x_q, s0_y_q, s0_z_q;
  logic [EW-1:0] s0_edge_q;
  logic [IW-1:0] s0_gidx_q;
  mid_t          s1_d, s1_q, s2_q;
  pipe_t         s3_d, s3_q;

  logic          dx, dy, dz;
  axis_e         ax;
  logic [RW-1:0] ya, za, mul_a;
  logic [PW-1:0] mul_b;

  always_comb begin
    dx = 1'b0;
    dy = 1'b0;
    dz = 1'b0;
    ax = AX_NONE;
    case (s0_edge_q)
      EDGE_X00: begin ax = AX_X; end
      EDGE_X10: begin ax = AX_X; dy = 1'b1; end
      EDGE_X01: begin ax = AX_X; dz = 1'b1; end
      EDGE_X11: begin ax = AX_X; dy = 1'b1; dz = 1'b1; end
      EDGE_Y00: begin ax = AX_Y; end
      EDGE_Y10: begin ax = AX_Y; dx = 1'b1; end
      EDGE_Y01: begin ax = AX_Y; dz = 1'b1; end
      EDGE_Y11: begin ax = AX_Y; dx = 1'b1; dz = 1'b1; end
      EDGE_Z00: begin ax = AX_Z; end
      EDGE_Z10: begin ax = AX_Z; dx = 1'b1; end
      EDGE_Z01: begin ax = AX_Z; dy = 1'b1; end
      EDGE_Z11: begin ax = AX_Z; dx = 1'b1; dy = 1'b1; end
      default: ;
    endcase
    ya = {1'b0, s0_y_q} + RW'(dy);
    za = {1'b0, s0_z_q} + RW'(dz);
    case (ax)
      AX_X:    begin mul_a = cfg_i.rx;        mul_b = cfg_i.px; end
      AX_Y:    begin mul_a = cfg_i.rx + 1'b1; mul_b = cfg_i.py; end
      AX_Z:    begin mul_a = cfg_i.rx + 1'b1; mul_b = cfg_i.pz; end
      default: begin mul_a = '0;              mul_b = '0;       end
    endcase
    s1_d.valid = s0_valid_q;
    s1_d.cmd   = s0_cmd_q;
    s1_d.axis  = ax;
    s1_d.xa    = {1'b0, s0_x_q} + RW'(dx);
    s1_d.pa    = mul_a * ya;
    s1_d.pb    = IW'(mul_b * za);
    s1_d.gidx  = s0_gidx_q;
  end

  // forward sum, or choose the axis block and its row and plane
  always_comb begin
    s3_d       = '0;
    s3_d.valid = s2_q.valid;
    s3_d.cmd   = s2_q.cmd;
    if (s2_q.cmd == CMD_FWD) begin
      s3_d.axis = s2_q.axis;
      case (s2_q.axis)
        AX_X: s3_d.num = IW'(s2_q.xa) + IW'(s2_q.pa) + s2_q.pb;
        AX_Y: s3_d.num = cfg_i.xc + IW'(s2_q.xa) + IW'(s2_q.pa) + s2_q.pb;
        AX_Z: s3_d.num = cfg_i.xyc + IW'(s2_q.xa) + IW'(s2_q.pa) + s2_q.pb;
        default: s3_d.num = '0;
      endcase
    end else if (s2_q.gidx < cfg_i.xc) begin
      s3_d.axis  = AX_X;
      s3_d.num   = s2_q.gidx;
      s3_d.row   = cfg_i.rx;
      s3_d.plane = cfg_i.px;
    end else if (s2_q.gidx < cfg_i.xyc) begin
      s3_d.axis  = AX_Y;
      s3_d.num   = s2_q.gidx - cfg_i.xc;
      s3_d.row   = cfg_i.rx + 1'b1;
      s3_d.plane = cfg_i.py;
    end else begin
      s3_d.axis  = AX_Z;
      s3_d.num   = s2_q.gidx - cfg_i.xyc;
      s3_d.row   = cfg_i.rx + 1'b1;
      s3_d.plane = cfg_i.pz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
    end else if (en_i) begin
      s0_valid_q <= in_valid_i;
      s1_q       <= s1_d;
      s2_q       <= s1_q;
      s3_q       <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_cmd_q  <= in_cmd_i;
      s0_x_q    <= in_x_i;
      s0_y_q    <= in_y_i;
      s0_z_q    <= in_z_i;
      s0_edge_q <= in_edge_i;
      s0_gidx_q <= in_gidx_i;
    end
  end

  assign out_o = s3_q;

endmodule

// ===== rtl/vei_div.sv =====
// ----------------------------------------------------------------------------
// vei_div
// Pipelined restoring divider: rem / plane one bit per stage, then the
// remainder / row one bit per stage. Forward items pass unchanged.
// ----------------------------------------------------------------------------
module vei_div import vei_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  pipe_t in_i,
  output pipe_t out_o
);

  pipe_t st_q [DIV_STAGES+1];
  pipe_t st_d [DIV_STAGES];

  assign st_q[0] = in_i;

  for (genvar k = 0; k < PLANE_STEPS; k++) begin : g_plane
    logic [PW:0] t;
    logic        ge;
    always_comb begin
      t  = {st_q[k].rmd, st_q[k].num[IW-1]};
      ge = (t >= {1'b0, st_q[k].plane});
      st_d[k] = st_q[k];
      if (st_q[k].cmd == CMD_INV) begin
        st_d[k].rmd = ge ? PW'(t - {1'b0, st_q[k].plane}) : t[PW-1:0];
        st_d[k].num = {st_q[k].num[IW-2:0], ge};
      end
    end
  end

  for (genvar j = 0; j < ROW_STEPS; j++) begin : g_row
    localparam int unsigned BI = ROW_STEPS - 1 - j;
    logic [RW-1:0] p;
    logic [RW:0]   t;
    logic          ge;
    always_comb begin
      // first row step starts from the bits above the quotient field
      if (j == 0) begin
        p = RW'(st_q[PLANE_STEPS+j].rmd[PW-1:ROW_STEPS]);
      end else begin
        p = st_q[PLANE_STEPS+j].part;
      end
      t  = {p, st_q[PLANE_STEPS+j].rmd[BI]};
      ge = (t >= {1'b0, st_q[PLANE_STEPS+j].row});
      st_d[PLANE_STEPS+j] = st_q[PLANE_STEPS+j];
      if (st_q[PLANE_STEPS+j].cmd == CMD_INV) begin
        st_d[PLANE_STEPS+j].part    = ge ? RW'(t - {1'b0, st_q[PLANE_STEPS+j].row})
                                         : t[RW-1:0];
        st_d[PLANE_STEPS+j].rmd[BI] = ge;
      end
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k+1] <= '0;
      end else if (en_i) begin
        st_q[k+1] <= st_d[k];
      end
    end
  end

  assign out_o = st_q[DIV_STAGES];

endmodule

// ===== rtl/vei_back.sv =====
// ----------------------------------------------------------------------------
// vei_back
// Endpoint saturation and the output register.
// ----------------------------------------------------------------------------
module vei_back import vei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  pipe_t         in_i,
  output logic          valid_o,
  output logic [IW-1:0] gidx_o,
  output logic [RW-1:0] sx_o,
  output logic [RW-1:0] sy_o,
  output logic [RW-1:0] sz_o,
  output logic [RW-1:0] ex_o,
  output logic [RW-1:0] ey_o,
  output logic [RW-1:0] ez_o
);

  logic          valid_q;
  logic [IW-1:0] gidx_q, gidx_d;
  logic [RW-1:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
  logic [RW-1:0] sx_d, sy_d, sz_d, ex_d, ey_d, ez_d;

  always_comb begin
    gidx_d = '0;
    sx_d   = '0;
    sy_d   = '0;
    sz_d   = '0;
    if (in_i.cmd == CMD_FWD) begin
      gidx_d = in_i.num;
    end else begin
      sx_d = in_i.part;
      sy_d = in_i.rmd[RW-1:0];
      sz_d = (in_i.num > IW'(MAX_RANGE)) ? RW'(MAX_RANGE) : in_i.num[RW-1:0];
    end
    ex_d = sx_d;
    ey_d = sy_d;
    ez_d = sz_d;
    if (in_i.cmd == CMD_INV) begin
      case (in_i.axis)
        AX_X:    ex_d = sat_inc(sx_d);
        AX_Y:    ey_d = sat_inc(sy_d);
        AX_Z:    ez_d = sat_inc(sz_d);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gidx_q <= gidx_d;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      sz_q   <= sz_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      ez_q   <= ez_d;
    end
  end

  assign valid_o = valid_q;
  assign gidx_o  = gidx_q;
  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign sz_o    = sz_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign ez_o    = ez_q;

endmodule
